[rtl/assert_macros.svh]
// Assertion macros for the checker file of the tick unwrap block.
// No dependencies; included by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Full property, reset-qualified.
`define WTUS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wtus: property violated");

// Same-cycle implication, reset-qualified.
`define WTUS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wtus: implication violated");

`endif

[rtl/wtus_pkg.sv]
// Shared types and constants of the tick unwrap and scale block.
// No dependencies; used by all rtl modules through scoped names.
package wtus_pkg;

  localparam int unsigned SAMPLE_W  = 32;  // tick_sample port width
  localparam int unsigned TPS_W     = 20;  // ticks_per_second width
  localparam int unsigned TIME_W    = 63;  // accumulated ticks and result width
  localparam int unsigned DAY_W     = 17;
  localparam int unsigned LIMIT_W   = TPS_W + DAY_W;
  localparam int unsigned DIV_DW    = 64;  // divider dividend / quotient width
  localparam int unsigned NS_W      = 30;
  localparam int unsigned SEC_LIM_W = 34;
  localparam int unsigned MUL_W     = SEC_LIM_W / 2;  // partial product slice
  localparam int unsigned Q_DEPTH   = 2;

  localparam logic [TPS_W-1:0]     TPS_RESET       = TPS_W'(100);
  localparam logic [DAY_W-1:0]     SECONDS_PER_DAY = DAY_W'(86400);
  localparam logic [NS_W-1:0]      NS_PER_SEC      = NS_W'(1000000000);
  // Largest whole-second count whose nanosecond value can still fit 63 bits.
  localparam logic [SEC_LIM_W-1:0] SEC_LIMIT       = SEC_LIM_W'(64'd9223372036);
  localparam logic [TIME_W-1:0]    TIME_MAX        = {TIME_W{1'b1}};

  // One accumulated result handed from front to back.
  typedef struct packed {
    logic [TIME_W-1:0] acc;
    logic              jump;
  } q_entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic [TPS_W-1:0]  rem;
  } div_rsp_t;

endpackage

[rtl/wtus_fifo.sv]
// Short queue between the front (accumulate) and back (scale) stages.
// Depends on wtus_pkg for the entry type and depth.
module wtus_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  wtus_pkg::q_entry_t  push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output wtus_pkg::q_entry_t  pop_entry_o
);

  localparam int unsigned PTR_W = (wtus_pkg::Q_DEPTH > 1) ? $clog2(wtus_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(wtus_pkg::Q_DEPTH + 1);

  wtus_pkg::q_entry_t mem_q [wtus_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(wtus_pkg::Q_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(wtus_pkg::Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[rtl/wtus_div.sv]
// Iterative unsigned divider, radix 4 (two quotient bits per cycle).
// Depends on wtus_pkg for widths and request/response types.
module wtus_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wtus_pkg::div_req_t         req_i,
  input  logic [wtus_pkg::TPS_W-1:0] divisor_i,
  output wtus_pkg::div_rsp_t         rsp_o
);

  localparam int unsigned DW    = wtus_pkg::DIV_DW;
  localparam int unsigned RW    = wtus_pkg::TPS_W;
  localparam int unsigned STEPS = DW / 2;
  localparam int unsigned CW    = $clog2(STEPS);

  logic [RW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  logic [RW:0]   r1, r2, dv;
  logic [RW-1:0] r1a;
  logic          q1, q2;

  // Two restoring steps; the partial remainder stays below the divisor.
  always_comb begin
    dv  = {1'b0, divisor_i};
    r1  = {rem_q, quo_q[DW-1]};
    q1  = (r1 >= dv);
    r1a = q1 ? RW'(r1 - dv) : r1[RW-1:0];
    r2  = {r1a, quo_q[DW-2]};
    q2  = (r2 >= dv);
    rem_d = q2 ? RW'(r2 - dv) : r2[RW-1:0];
    quo_d = {quo_q[DW-3:0], q1, q2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        cnt_q  <= CW'(STEPS - 1);
        busy_q <= 1'b1;
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/wtus_front.sv]
// Front stage: takes tick samples, unwraps the step, checks the one-day
// jump limit and accumulates. Depends on wtus_pkg; feeds wtus_fifo.
module wtus_front #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wtus_pkg::SAMPLE_W-1:0] tick_sample_i,
  input  logic [wtus_pkg::TPS_W-1:0]           tps_i,
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output wtus_pkg::q_entry_t                   push_entry_o
);

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned AW = wtus_pkg::TIME_W;
  localparam int unsigned LW = wtus_pkg::LIMIT_W;

  typedef enum logic [1:0] {F_IDLE, F_STEP, F_ACC} state_e;

  state_e         state_q;
  logic [SW-1:0]  now_q, prev_q, step_q;
  logic [AW-1:0]  acc_q;
  logic [LW-1:0]  limit_q, limit_d;

  logic [SW:0]    diff;
  logic           add_half;
  logic [SW-1:0]  step_d;
  logic [AW:0]    sum;
  logic [AW-1:0]  acc_add;
  logic           jump;

  assign limit_d = LW'(tps_i) * LW'(wtus_pkg::SECONDS_PER_DAY);

  // Step in SW+1 bits. Adding half the range flips the top bit; a step below
  // minus half needs a full range added, which the low bits already show.
  always_comb begin
    diff     = {now_q[SW-1], now_q} - {prev_q[SW-1], prev_q};
    add_half = diff[SW] & diff[SW-1];
    step_d   = {diff[SW-1] ^ add_half, diff[SW-2:0]};
  end

  always_comb begin
    jump    = (LW'(step_q) > limit_q);
    sum     = {1'b0, acc_q} + (AW + 1)'(step_q);
    acc_add = sum[AW] ? wtus_pkg::TIME_MAX : sum[AW-1:0];
    push_entry_o.acc  = jump ? acc_q : acc_add;
    push_entry_o.jump = jump;
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_ACC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      now_q   <= '0;
      prev_q  <= '0;
      step_q  <= '0;
      acc_q   <= '0;
      limit_q <= '0;
    end else begin
      limit_q <= limit_d;
      unique case (state_q)
        F_IDLE: begin
          if (in_valid_i) begin
            now_q   <= tick_sample_i[SW-1:0];
            state_q <= F_STEP;
          end
        end
        F_STEP: begin
          step_q  <= step_d;
          state_q <= F_ACC;
        end
        F_ACC: begin
          if (push_ready_i) begin
            if (!jump) begin
              acc_q  <= acc_add;
              prev_q <= now_q;
            end
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/wtus_back.sv]
// Back stage: scales the accumulated count into seconds and nanoseconds
// using the shared divider, and holds the result register.
// Depends on wtus_pkg; drives wtus_div, reads wtus_fifo.
module wtus_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  wtus_pkg::q_entry_t          pop_entry_i,
  output wtus_pkg::div_req_t          div_req_o,
  input  wtus_pkg::div_rsp_t          div_rsp_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [wtus_pkg::TIME_W-1:0] time_ns_o,
  output logic [wtus_pkg::TIME_W-1:0] time_seconds_o,
  output logic                        jump_error_o
);

  localparam int unsigned TW  = wtus_pkg::TIME_W;
  localparam int unsigned DW  = wtus_pkg::DIV_DW;
  localparam int unsigned RW  = wtus_pkg::TPS_W;
  localparam int unsigned NW  = wtus_pkg::NS_W;
  localparam int unsigned MW  = wtus_pkg::MUL_W;
  localparam int unsigned RPW = RW + NW;
  localparam int unsigned PPW = MW + NW;

  typedef enum logic [2:0] {
    B_IDLE, B_DIV1, B_MUL1, B_DIV2, B_MULA, B_MULB, B_SUM, B_OUT
  } state_e;

  state_e             state_q;
  wtus_pkg::div_req_t req_q;
  logic               jump_q, sat_q, out_valid_q, jump_out_q;
  logic [TW-1:0]      secs_q, ns_out_q, secs_out_q;
  logic [RW-1:0]      rem_q;
  logic [NW-1:0]      frac_q;
  logic [DW-1:0]      prod_q, sum_q;

  logic [RPW-1:0]     rem_ns;
  logic [PPW-1:0]     mul_lo, mul_hi;
  logic [TW-1:0]      ns_val;
  logic               out_free;

  assign rem_ns   = RPW'(rem_q) * RPW'(wtus_pkg::NS_PER_SEC);
  assign mul_lo   = PPW'(secs_q[MW-1:0]) * PPW'(wtus_pkg::NS_PER_SEC);
  assign mul_hi   = PPW'(secs_q[2*MW-1:MW]) * PPW'(wtus_pkg::NS_PER_SEC);
  assign ns_val   = (sat_q || sum_q[DW-1]) ? wtus_pkg::TIME_MAX : sum_q[TW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  assign pop_ready_o    = (state_q == B_IDLE);
  assign div_req_o      = req_q;
  assign out_valid_o    = out_valid_q;
  assign time_ns_o      = ns_out_q;
  assign time_seconds_o = secs_out_q;
  assign jump_error_o   = jump_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      req_q       <= '0;
      jump_q      <= 1'b0;
      sat_q       <= 1'b0;
      secs_q      <= '0;
      rem_q       <= '0;
      frac_q      <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      ns_out_q    <= '0;
      secs_out_q  <= '0;
      jump_out_q  <= 1'b0;
    end else begin
      req_q.start <= 1'b0;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            req_q.start    <= 1'b1;
            req_q.dividend <= DW'(pop_entry_i.acc);
            jump_q         <= pop_entry_i.jump;
            state_q        <= B_DIV1;
          end
        end
        B_DIV1: begin
          if (div_rsp_i.done) begin
            secs_q  <= div_rsp_i.quot[TW-1:0];
            rem_q   <= div_rsp_i.rem;
            state_q <= B_MUL1;
          end
        end
        B_MUL1: begin
          // Fraction dividend: remainder scaled to nanoseconds.
          req_q.start    <= 1'b1;
          req_q.dividend <= DW'(rem_ns);
          state_q        <= B_DIV2;
        end
        B_DIV2: begin
          if (div_rsp_i.done) begin
            frac_q  <= div_rsp_i.quot[NW-1:0];
            state_q <= B_MULA;
          end
        end
        B_MULA: begin
          prod_q  <= DW'(mul_lo);
          state_q <= B_MULB;
        end
        B_MULB: begin
          prod_q  <= prod_q + (DW'(mul_hi) << MW);
          state_q <= B_SUM;
        end
        B_SUM: begin
          sum_q   <= prod_q + DW'(frac_q);
          sat_q   <= (secs_q > TW'(wtus_pkg::SEC_LIMIT));
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ns_out_q    <= ns_val;
            secs_out_q  <= secs_q;
            jump_out_q  <= jump_q;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/wrapping_tick_unwrap_and_scale_unit.sv]
// Top level of the wrapping tick unwrap and scale block.
// Depends on wtus_pkg, wtus_front, wtus_fifo, wtus_back and wtus_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / tick_sample_i) takes one raw
//   counter sample per item. The front unwraps the step from the previous
//   sample, flags steps longer than one day of ticks as jump errors and
//   adds valid steps to a saturating 63-bit tick count.
//   Output channel (out_valid_o / out_ready_i) returns one item per sample:
//   time_ns_o, time_seconds_o and jump_error_o.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
//   ticks_per_second; write it only while no item is in flight.
//   Pacing: set by the back stage, which runs two 32-step radix-4 divisions
//   on the shared divider per item (whole seconds, then the nanosecond
//   fraction) and takes no new item until its last result is registered.
//   The front takes a new sample only once the last one is pushed, and
//   runs ahead through a two-entry queue.
//   Reset: tick count and previous sample clear to zero, tick rate to 100.
//   Receiver stall: the result register holds; the back stage finishes the
//   next item and waits; the front keeps accepting until the queue is full.
module wrapping_tick_unwrap_and_scale_unit #(
  parameter int unsigned SAMPLE_BITS = 32  // sample bits in use, 16 to 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [wtus_pkg::SAMPLE_W-1:0] tick_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [wtus_pkg::TIME_W-1:0]          time_ns_o,
  output logic [wtus_pkg::TIME_W-1:0]          time_seconds_o,
  output logic                                 jump_error_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wtus_pkg::TPS_W-1:0]           cfg_data_i
);

  logic [wtus_pkg::TPS_W-1:0] tps_q, tps_eff;

  logic                 push_valid, push_ready;
  wtus_pkg::q_entry_t   push_entry;
  logic                 pop_valid, pop_ready;
  wtus_pkg::q_entry_t   pop_entry;
  wtus_pkg::div_req_t   div_req;
  wtus_pkg::div_rsp_t   div_rsp;

  // Config register; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= wtus_pkg::TPS_RESET;
    end else if (cfg_valid_i) begin
      tps_q <= cfg_data_i;
    end
  end

  // A zero rate scales as one tick per second.
  assign tps_eff = (tps_q == '0) ? wtus_pkg::TPS_W'(1) : tps_q;

  wtus_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tick_sample_i (tick_sample_i),
    .tps_i         (tps_eff),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  wtus_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  wtus_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_entry_i    (pop_entry),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .time_ns_o      (time_ns_o),
    .time_seconds_o (time_seconds_o),
    .jump_error_o   (jump_error_o)
  );

  wtus_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (tps_eff),
    .rsp_o     (div_rsp)
  );

endmodule

[rtl/wtus_checker.sv]
// Port-level checker for the tick unwrap and scale block, bound to the top.
// Depends on assert_macros.svh and wtus_pkg.
`include "assert_macros.svh"

module wtus_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [wtus_pkg::TIME_W-1:0] time_ns_o,
  input logic [wtus_pkg::TIME_W-1:0] time_seconds_o,
  input logic                        jump_error_o
);

  logic                        out_hold;
  logic [2*wtus_pkg::TIME_W:0] payload;

  assign out_hold = out_valid_o && !out_ready_i;
  assign payload  = {time_ns_o, time_seconds_o, jump_error_o};

  // Front drops ready after taking an item.
  `WTUS_ASSERT(a_in_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)

  // Nanoseconds never fall below whole seconds, saturated or not.
  `WTUS_ASSERT_IMPL(a_ns_not_below_secs, clk_i, rst_ni, out_valid_o, time_ns_o >= time_seconds_o)

  `WTUS_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_hold |=> out_valid_o)

  `WTUS_ASSERT(a_out_payload_holds, clk_i, rst_ni, out_hold |=> $stable(payload))

endmodule

bind wrapping_tick_unwrap_and_scale_unit wtus_checker u_wtus_checker (.*);

[tb/tick_scale_checker.sv]
// Scoreboard for the wrapping tick unwrap and scale block: watches all three
// channels, keeps its own copy of the tick state and checks every result item.
// Depends on wtus_pkg for widths and the reset tick rate.
module tick_scale_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [wtus_pkg::SAMPLE_W-1:0] tick_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [wtus_pkg::TIME_W-1:0]          time_ns_i,
  input  logic [wtus_pkg::TIME_W-1:0]          time_seconds_i,
  input  logic                                 jump_error_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [wtus_pkg::TPS_W-1:0]           cfg_data_i,
  output int                                   error_count_o,
  output int                                   pending_count_o,
  output int                                   result_count_o,
  output int                                   jump_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TICKS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned NS_PER_SEC  = 64'd1_000_000_000;
  localparam longint          DAY_SECONDS = 64'sd86400;
  localparam longint          HALF_RANGE  = 64'sd2147483648;  // wrap correction
  localparam int              MAX_PRINTED = 100;

  typedef struct {
    logic [wtus_pkg::TIME_W-1:0] ns;
    logic [wtus_pkg::TIME_W-1:0] secs;
    logic                        jump;
  } tick_time_t;

  tick_time_t                        expected_times[$];
  tick_time_t                        want;
  longint unsigned                   acc_ticks;
  logic signed [wtus_pkg::SAMPLE_W-1:0] last_tick;
  logic [wtus_pkg::TPS_W-1:0]        rate;
  int                                mismatches = 0;
  int                                results = 0;
  int                                jumps = 0;

  assign error_count_o  = mismatches;
  assign result_count_o = results;
  assign jump_count_o   = jumps;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Advances the tick state by one sample and returns the time it reports.
  function automatic tick_time_t accumulate_tick(input logic signed [31:0] tick);
    longint unsigned rate_eff, secs, rem, frac;
    longint          stride, day_limit;
    tick_time_t      t;
    rate_eff = (rate == 0) ? 64'd1 : 64'(rate);  // zero rate counts as one
    stride = longint'(tick) - longint'(last_tick);
    while (stride < 0) stride += HALF_RANGE;
    day_limit = DAY_SECONDS * longint'(rate_eff);
    t.jump = (stride > day_limit);
    if (!t.jump) begin
      if ($unsigned(stride) > TICKS_MAX - acc_ticks) acc_ticks = TICKS_MAX;
      else acc_ticks += $unsigned(stride);
      last_tick = tick;
    end
    secs = acc_ticks / rate_eff;
    rem  = acc_ticks % rate_eff;
    frac = (rem * NS_PER_SEC) / rate_eff;
    if (secs > (TICKS_MAX - frac) / NS_PER_SEC) t.ns = TICKS_MAX[wtus_pkg::TIME_W-1:0];
    else t.ns = wtus_pkg::TIME_W'(secs * NS_PER_SEC + frac);
    t.secs = wtus_pkg::TIME_W'(secs);
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_ticks = 0;
      last_tick = '0;
      rate      = wtus_pkg::TPS_RESET;
      expected_times.delete();
      pending_count_o <= 0;
    end else begin
      // Results leave before new samples land: a result never belongs to a
      // sample taken on the same edge.
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_times.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (ns %0d)", time_ns_i));
        end else begin
          want = expected_times.pop_front();
          if (time_ns_i !== want.ns)
            report_mismatch($sformatf("time_ns got %0d, expected %0d", time_ns_i, want.ns));
          if (time_seconds_i !== want.secs)
            report_mismatch($sformatf("time_seconds got %0d, expected %0d",
                                      time_seconds_i, want.secs));
          if (jump_error_i !== want.jump)
            report_mismatch($sformatf("jump_error got %b, expected %b",
                                      jump_error_i, want.jump));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = accumulate_tick(tick_sample_i);
        if (want.jump) jumps++;
        expected_times.push_back(want);
      end
      if (cfg_valid_i && cfg_ready_i) rate = cfg_data_i;
      pending_count_o <= expected_times.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the testbench for wrapping_tick_unwrap_and_scale_unit: clock, reset,
// stimulus on the sample and tick-rate channels, output stalls and the verdict.
// Depends on wtus_pkg, the block itself and tick_scale_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WATCHDOG_LIMIT  = 4000;  // quiet cycles before giving up
  localparam int     PHASES          = 10;
  localparam int     ITEMS_PER_PHASE = 138;
  localparam int     DRAIN_CYCLES    = 100;
  localparam longint WRAP_STEP       = 64'sd2147483648;
  localparam longint STEP_CEIL       = 64'sd2147483647;
  localparam longint DAY_SECONDS     = 64'sd86400;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [wtus_pkg::SAMPLE_W-1:0] tick_sample_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic [wtus_pkg::TIME_W-1:0]          time_ns_o;
  logic [wtus_pkg::TIME_W-1:0]          time_seconds_o;
  logic                                 jump_error_o;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [wtus_pkg::TPS_W-1:0]           cfg_data_i;

  int  mismatches, pending, results, jumps;

  // Stimulus-side view of the counter: the last sample the block should have
  // kept, and the tick rate in force (zero already mapped to one).
  logic signed [31:0] cursor;
  longint             rate_eff;
  bit                 no_idling;
  int                 samples_sent;
  int                 rate_writes;
  int                 ready_hold = 0;
  int                 ready_span;
  int                 quiet_cycles;
  wire                any_accept = (in_valid_i && in_ready_o) ||
                                   (out_valid_o && out_ready_i) ||
                                   (cfg_valid_i && cfg_ready_o);

  wrapping_tick_unwrap_and_scale_unit #(
    .SAMPLE_BITS(32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tick_sample_i (tick_sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .time_ns_o     (time_ns_o),
    .time_seconds_o(time_seconds_o),
    .jump_error_o  (jump_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  tick_scale_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .tick_sample_i  (tick_sample_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .time_ns_i      (time_ns_o),
    .time_seconds_i (time_seconds_o),
    .jump_error_i   (jump_error_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (mismatches),
    .pending_count_o(pending),
    .result_count_o (results),
    .jump_count_o   (jumps)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one. Zero while a
  // full-speed stretch is running.
  function automatic int idle_span();
    int unsigned pick;
    if (no_idling) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 150);
  endfunction

  // True when the block should accept the sample as a normal step (no jump),
  // i.e. the unwrapped distance from the cursor fits within one day of ticks.
  function automatic bit sample_kept(input logic signed [31:0] value);
    longint stride;
    stride = longint'(value) - longint'(cursor);
    while (stride < 0) stride += WRAP_STEP;
    return stride <= DAY_SECONDS * rate_eff;
  endfunction

  // Random sample, shaped so most items are plausible counter advances.
  function automatic logic signed [31:0] next_tick();
    longint      reach, d, sum;
    int unsigned pick;
    reach = DAY_SECONDS * rate_eff;
    if (reach > STEP_CEIL) reach = STEP_CEIL;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // Legal advance: none, exactly one day, small, or anywhere up to a day.
      pick = $urandom_range(0, 99);
      if (pick < 8) d = 0;
      else if (pick < 16) d = reach;
      else if (pick < 50) d = longint'($urandom_range(1, 1000));
      else d = longint'($urandom_range(0, 32'(reach)));
      if (d > reach) d = reach;
      // When the cursor is not negative, half of them wrap like a 31-bit
      // unsigned counter; the rest wrap like a signed 32-bit one.
      if (cursor >= 0 && $urandom_range(0, 1)) sum = (longint'(cursor) + d) % WRAP_STEP;
      else sum = longint'(cursor) + d;
    end else if (pick < 85 && reach < STEP_CEIL) begin
      // Advance past the one-day window: must be flagged.
      d = longint'($urandom_range(32'(reach + 1), 32'(STEP_CEIL)));
      sum = longint'(cursor) + d;
    end else begin
      sum = longint'($urandom());  // raw noise
    end
    return sum[31:0];
  endfunction

  // Valid stays up into the next item when there is no gap; this task lowers
  // it only before a gap, never right after acceptance.
  task automatic send_sample(input logic signed [31:0] value);
    int span;
    span = idle_span();
    if (span > 0) begin
      in_valid_i <= 1'b0;
      repeat (span) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    tick_sample_i <= value;
    if (sample_kept(value)) cursor = value;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
  endtask

  // Tick rate changes only with nothing in flight; every sample gives a
  // result, so an empty scoreboard means the block is idle.
  task automatic write_rate(input logic [wtus_pkg::TPS_W-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rate_eff = (value == 0) ? 64'sd1 : longint'(value);
    rate_writes++;
  endtask

  task automatic directed_checks();
    // Reset rate of 100: one day is 8640000 ticks.
    send_sample(32'sd0);                        // no movement
    send_sample(32'sd8640000);                  // exactly one day
    send_sample(32'sd17280001);                 // one tick past a day: jump
    send_sample(32'sh7FFF_FFFF);                // largest sample, jump
    send_sample(32'sh8000_0000);                // smallest sample, jump
    send_sample(32'sd8640100);                  // normal step after jumps
    send_sample(-32'sd1);                       // backwards: wraps to a jump
    // Fast counter: no step can exceed a day.
    write_rate(20'd1000000);
    send_sample(32'sh7FFF_FFF0);                // huge forward step
    send_sample(32'sh8000_0005);                // signed 32-bit wrap
    send_sample(32'sh7FFF_FFFF);                // step of almost 2^32
    send_sample(32'sh0000_0010);                // 31-bit unsigned wrap
    send_sample(-32'sd1);
    // Zero rate behaves as one tick per second.
    write_rate('0);
    send_sample(32'sd86399);                    // exactly one day
    send_sample(32'sd172800);                   // one past a day: jump
    send_sample(32'sd86399);                    // repeat sample
    write_rate('1);                             // largest 20-bit rate
    send_sample(32'sh8000_0000);                // double wrap correction
    write_rate(20'd1);
    send_sample(-32'sd2147397248);              // one day on from the bottom
    send_sample(-32'sd2147310847);              // one past a day: jump
  endtask

  // Output side: random stall and ready stretches, always ready at full speed.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_span = idle_span();
      if (ready_span == 0) begin
        out_ready_i <= 1'b1;
        ready_hold = $urandom_range(0, 15);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold = ready_span - 1;
      end
    end
  end

  // Gives up once nothing has moved on any channel for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || any_accept) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    tick_sample_i = '0;
    out_ready_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    cursor        = '0;
    rate_eff      = longint'(wtus_pkg::TPS_RESET);
    no_idling     = 1'b0;
    samples_sent  = 0;
    rate_writes   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_checks();

    // Random phases: the rate extremes first, then random rates; two of the
    // phases run with no gaps or stalls at all.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_rate(20'd1);
        1: write_rate(20'd100);
        2: write_rate(20'd1000000);
        3: write_rate('0);
        4: write_rate('1);
        default: begin
          if ($urandom_range(0, 1)) write_rate(20'($urandom_range(1, 1000000)));
          else write_rate(20'($urandom_range(1, 30000)));
        end
      endcase
      no_idling = (p == 3 || p == 7);
      repeat (ITEMS_PER_PHASE) send_sample(next_tick());
    end
    no_idling = 1'b0;

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples over %0d tick-rate writes; %0d results checked, %0d jumps.",
             samples_sent, rate_writes, results, jumps);
    $display("Rates included zero, one, 100, 1000000 and the 20-bit maximum.");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/wtus_pkg.sv
rtl/wtus_fifo.sv
rtl/wtus_div.sv
rtl/wtus_front.sv
rtl/wtus_back.sv
rtl/wrapping_tick_unwrap_and_scale_unit.sv
rtl/wtus_checker.sv
tb/tick_scale_checker.sv
tb/tb.sv
